FILE: rtl/mi4_pkg.sv
`timescale 1ns / 1ps
package mi4_pkg;

  localparam int EW    = 32;
  localparam int CW    = 100;
  localparam int DW    = 132;
  localparam int DIM   = 4;
  localparam int CELLS = DIM * DIM;
  localparam int IW    = 4;
  localparam int TERMS = 6;

  // column picked in row n of a 3x3 minor by permutation t; t >= 3 are the odd ones
  function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] n);
    logic [5:0] p;
    unique case (t)
      3'd0:    p = {2'd2, 2'd1, 2'd0};
      3'd1:    p = {2'd0, 2'd2, 2'd1};
      3'd2:    p = {2'd1, 2'd0, 2'd2};
      3'd3:    p = {2'd1, 2'd2, 2'd0};
      3'd4:    p = {2'd0, 2'd1, 2'd2};
      3'd5:    p = {2'd2, 2'd0, 2'd1};
      default: p = {2'd2, 2'd1, 2'd0};
    endcase
    unique case (n)
      2'd0:    perm_col = p[1:0];
      2'd1:    perm_col = p[3:2];
      default: perm_col = p[5:4];
    endcase
  endfunction

endpackage

FILE: rtl/mi4_ram.sv
`timescale 1ns / 1ps
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/matrix_inverse_4x4_unit.sv
`timescale 1ns / 1ps
// channel  | direction | handshake            | payload
// input    | in        | in_valid / in_stall   | element_value
// output   | out       | out_valid / out_stall | result_value, result_index, singular,
//          |           |                       | saturated, last
// a matrix loads in 16 beats, one per cycle; the block then stalls its input
// cofactors: 16 x 6 terms through one 1-bit-per-cycle 132-bit multiplier, and the
// determinant adds 4 more multiplies; each result goes through a 1-bit-per-cycle
// restoring divider of 100 + 2*FRACTION_BITS steps
// rst is synchronous; a stalled result holds in the output register until taken
module matrix_inverse_4x4_unit import mi4_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [EW-1:0] element_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [EW-1:0] result_value,
  output logic [IW-1:0]        result_index,
  output logic                 singular,
  output logic                 saturated,
  output logic                 last
);

  localparam int NW = CW + 2 * FRACTION_BITS;
  localparam int BW = $clog2(NW);

  typedef enum logic [3:0] {
    S_LOAD, S_FETCH, S_TAKE, S_MUL, S_MULD, S_COFW, S_NEXTK,
    S_DSGN, S_CFETCH, S_CTAKE, S_DIV, S_DFIN, S_OUT
  } state_t;

  state_t             state;
  logic [IW-1:0]      load_count;
  logic [IW-1:0]      k;
  logic [2:0]         term;
  logic [1:0]         fac;
  logic               det_mul;
  logic [BW-1:0]      bitcnt;
  logic [DW-1:0]      mcand;
  logic [EW-1:0]      mplier;
  logic [DW-1:0]      mul_acc;
  logic [DW-1:0]      prod;
  logic [DW-1:0]      cof_acc;
  logic [DW-1:0]      det;
  logic [DW-1:0]      dmag;
  logic               det_neg;
  logic               nneg;
  logic [NW-1:0]      num;
  logic [DW-1:0]      rem;
  logic [EW:0]        quo;
  logic               big;

  logic [IW-1:0]      m_raddr;
  logic [EW-1:0]      m_rdata;
  logic               c_we;
  logic [CW-1:0]      c_rdata;

  logic [1:0]         ci, cj, row, pc, col;
  logic               term_neg;
  logic [DW:0]        rem_sh;
  logic               rem_ge;
  logic [CW-1:0]      cabs;
  logic               qbig, qneg, qsat;
  logic [EW-1:0]      qval;

  mi4_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_mat (
    .clk   (clk),
    .we    (in_valid && !in_stall),
    .waddr (load_count),
    .wdata (element_value),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  mi4_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_cof (
    .clk   (clk),
    .we    (c_we),
    .waddr (k),
    .wdata (cof_acc[CW-1:0]),
    .raddr (k),
    .rdata (c_rdata)
  );

  // adjugate slot k = r*4 + c holds the cofactor of element (c, r)
  always_comb begin
    ci       = k[1:0];
    cj       = k[3:2];
    row      = fac + ((fac >= ci) ? 2'd1 : 2'd0);
    pc       = perm_col(term, fac);
    col      = pc + ((pc >= cj) ? 2'd1 : 2'd0);
    term_neg = (term >= 3'd3) ^ ci[0] ^ cj[0];
    m_raddr  = det_mul ? {2'd0, cj} : {row, col};
    c_we     = (state == S_COFW);
    rem_sh   = {rem, num[NW-1]};
    rem_ge   = (rem_sh >= {1'b0, dmag});
    cabs     = c_rdata[CW-1] ? (~c_rdata + CW'(1)) : c_rdata;
    qbig     = big | quo[EW];
    qneg     = nneg ^ det_neg;
    if (qneg) begin
      qsat = qbig || (quo[EW-1:0] > {1'b1, {(EW-1){1'b0}}});
      qval = qsat ? {1'b1, {(EW-1){1'b0}}} : (~quo[EW-1:0] + EW'(1));
    end else begin
      qsat = qbig || quo[EW-1];
      qval = qsat ? {1'b0, {(EW-1){1'b1}}} : quo[EW-1:0];
    end
  end

  assign in_stall     = (state != S_LOAD);
  assign out_valid    = (state == S_OUT);
  assign result_index = k;
  assign last         = (k == IW'(CELLS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      k          <= '0;
      term       <= '0;
      fac        <= '0;
      det_mul    <= 1'b0;
      det        <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            load_count <= load_count + IW'(1);
            if (load_count == IW'(CELLS - 1)) begin
              k       <= '0;
              term    <= '0;
              fac     <= '0;
              det_mul <= 1'b0;
              cof_acc <= '0;
              det     <= '0;
              state   <= S_FETCH;
            end
          end
        end
        S_FETCH: state <= S_TAKE;
        S_TAKE: begin
          if (!det_mul && fac == 2'd0) begin
            prod  <= {{(DW-EW){m_rdata[EW-1]}}, m_rdata};
            fac   <= 2'd1;
            state <= S_FETCH;
          end else begin
            mcand   <= det_mul ? cof_acc : prod;
            mplier  <= m_rdata;
            mul_acc <= '0;
            bitcnt  <= '0;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          if (mplier[0]) begin
            mul_acc <= (bitcnt == BW'(EW - 1)) ? mul_acc - mcand : mul_acc + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          bitcnt <= bitcnt + BW'(1);
          if (bitcnt == BW'(EW - 1)) begin
            state <= S_MULD;
          end
        end
        S_MULD: begin
          if (det_mul) begin
            det     <= det + mul_acc;
            det_mul <= 1'b0;
            state   <= S_NEXTK;
          end else if (fac == 2'd1) begin
            prod  <= mul_acc;
            fac   <= 2'd2;
            state <= S_FETCH;
          end else begin
            cof_acc <= term_neg ? cof_acc - mul_acc : cof_acc + mul_acc;
            fac     <= 2'd0;
            if (term == 3'(TERMS - 1)) begin
              state <= S_COFW;
            end else begin
              term  <= term + 3'd1;
              state <= S_FETCH;
            end
          end
        end
        S_COFW: begin
          // first-row cofactors (adjugate first column) also feed the determinant
          if (ci == 2'd0) begin
            det_mul <= 1'b1;
            state   <= S_FETCH;
          end else begin
            state <= S_NEXTK;
          end
        end
        S_NEXTK: begin
          cof_acc <= '0;
          term    <= '0;
          k       <= k + IW'(1);
          state   <= (k == IW'(CELLS - 1)) ? S_DSGN : S_FETCH;
        end
        S_DSGN: begin
          det_neg <= det[DW-1];
          dmag    <= det[DW-1] ? (~det + DW'(1)) : det;
          state   <= S_CFETCH;
        end
        S_CFETCH: state <= S_CTAKE;
        S_CTAKE: begin
          nneg   <= c_rdata[CW-1];
          num    <= {cabs, {(2 * FRACTION_BITS){1'b0}}};
          rem    <= '0;
          quo    <= '0;
          big    <= 1'b0;
          bitcnt <= '0;
          if (det == '0) begin
            result_value <= '0;
            singular     <= 1'b1;
            saturated    <= 1'b0;
            state        <= S_OUT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem    <= rem_ge ? DW'(rem_sh - {1'b0, dmag}) : rem_sh[DW-1:0];
          quo    <= {quo[EW-1:0], rem_ge};
          big    <= big | quo[EW];
          num    <= num << 1;
          bitcnt <= bitcnt + BW'(1);
          if (bitcnt == BW'(NW - 1)) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          result_value <= qval;
          singular     <= 1'b0;
          saturated    <= qsat;
          state        <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            k     <= k + IW'(1);
            state <= (k == IW'(CELLS - 1)) ? S_LOAD : S_CFETCH;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule
